[src/src_pkg.sv]
// Package with the types, constants and arithmetic helpers of the sprite rectangle clipper.
package src_pkg;

   localparam int PosW  = 20;
   localparam int TexW  = 18;
   localparam int EdgeW = PosW + 1;
   localparam int FracW = 16;
   localparam int DivStages    = 8;
   localparam int BitsPerStage = FracW / DivStages;
   localparam int ProdW = (TexW + 1) + (FracW + 1);

   localparam logic signed [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};

   typedef enum logic [1:0] {
      REG_CLIP_LEFT   = 2'd0,
      REG_CLIP_TOP    = 2'd1,
      REG_CLIP_RIGHT  = 2'd2,
      REG_CLIP_BOTTOM = 2'd3
   } csr_reg_type;

   // Lane order: s at the left edge, t at the top, s at the right, t at the bottom.
   localparam int LaneS1 = 0;
   localparam int LaneT1 = 1;
   localparam int LaneS2 = 2;
   localparam int LaneT2 = 3;
   localparam int Lanes  = 4;

   typedef struct packed {
      logic signed [PosW-1:0]  x;
      logic signed [PosW-1:0]  y;
      logic signed [PosW-1:0]  w;
      logic signed [PosW-1:0]  h;
      logic signed [TexW-1:0]  s1;
      logic signed [TexW-1:0]  t1;
      logic signed [TexW-1:0]  s2;
      logic signed [TexW-1:0]  t2;
      logic signed [EdgeW-1:0] right;
      logic signed [EdgeW-1:0] bottom;
   } edge_type;

   typedef struct packed {
      logic                   clip;
      logic signed [TexW-1:0] a;
      logic signed [TexW-1:0] b;
      logic [EdgeW-1:0]       rem;
      logic [EdgeW-1:0]       ext;
      logic [FracW-1:0]       quo;
   } div_lane_type;

   typedef struct packed {
      logic                   culled;
      logic signed [PosW-1:0] x;
      logic signed [PosW-1:0] y;
      logic signed [PosW-1:0] w;
      logic signed [PosW-1:0] h;
      div_lane_type [Lanes-1:0] lane;
   } div_type;

   typedef struct packed {
      logic                    clip;
      logic signed [TexW-1:0]  a;
      logic signed [ProdW-1:0] prod;
   } mul_lane_type;

   typedef struct packed {
      logic                   culled;
      logic signed [PosW-1:0] x;
      logic signed [PosW-1:0] y;
      logic signed [PosW-1:0] w;
      logic signed [PosW-1:0] h;
      mul_lane_type [Lanes-1:0] lane;
   } mul_type;

   typedef struct packed {
      logic                   culled;
      logic signed [PosW-1:0] x;
      logic signed [PosW-1:0] y;
      logic signed [PosW-1:0] w;
      logic signed [PosW-1:0] h;
      logic signed [TexW-1:0] s1;
      logic signed [TexW-1:0] t1;
      logic signed [TexW-1:0] s2;
      logic signed [TexW-1:0] t2;
   } result_type;

   // Clamp a positive size to the largest Q16.4 value.
   function automatic logic signed [PosW-1:0] sat_size(input logic signed [EdgeW:0] v);
      if (v > (EdgeW+1)'(PosMax)) begin
         return PosMax;
      end
      return v[PosW-1:0];
   endfunction

   // Restoring division: two quotient bits of removed * 2^16 / extent.
   function automatic div_lane_type div_step(input div_lane_type l);
      div_lane_type  r;
      logic [EdgeW:0] t;
      r = l;
      for (int i = 0; i < BitsPerStage; i++) begin
         t = {r.rem, 1'b0};
         if (t >= {1'b0, r.ext}) begin
            t     = t - {1'b0, r.ext};
            r.quo = {r.quo[FracW-2:0], 1'b1};
         end else begin
            r.quo = {r.quo[FracW-2:0], 1'b0};
         end
         r.rem = t[EdgeW-1:0];
      end
      return r;
   endfunction

   // a + (product / 2^16) with the quotient truncated toward zero.
   function automatic logic signed [TexW-1:0] lerp_done(input mul_lane_type l);
      logic signed [ProdW-FracW-1:0] q;
      q = l.prod[ProdW-1:FracW];
      if (l.prod[ProdW-1] && (l.prod[FracW-1:0] != '0)) begin
         q = q + 1'b1;
      end
      return l.a + q[TexW-1:0];
   endfunction

endpackage

[src/sprite_rect_clipper_top.sv]
// Top level of the sprite rectangle clipper: configuration registers and the clipping pipeline.
//
// Usage: rectangles enter on the req_ stream, one beat each, carrying position, size and
// texture coordinates; one result beat per rectangle leaves on the rsp_ stream, with the
// culled flag in rsp_tuser. The clip window is held in four registers written through the
// csr_ port; the user must write them only while no rectangle is in flight, which the block
// does not enforce. A window that is empty in either direction (right not above left, or
// bottom not above top) passes rectangles through unchanged. A new beat can be taken in
// every cycle unless the receiver stalls and every stage is full: the pipeline is twelve
// register stages, two for edge sums and clip decisions, eight for the fraction divider
// (two quotient bits per stage), one for the texture multiply and one output register.
// Each stage moves on when it is empty or the stage after it moves, so bubbles are squeezed
// out while the receiver stalls, and req_tready falls only once every stage is full.
// Reset clears all valid bits and sets the window registers to zero (clipping off).
module sprite_rect_clipper_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // pos_x, pos_y, width, height, tex_s_start, tex_t_start, tex_s_end, tex_t_end
   input  logic [151:0]                  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_x, out_y, out_width, out_height, out_s_start, out_t_start, out_s_end, out_t_end
   output logic [151:0]                  rsp_tdata,
   // culled
   output logic                          rsp_tuser,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [3:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import src_pkg::*;

   localparam int Stages = DivStages + 4;

   logic signed [PosW-1:0] clip_left_ff, clip_top_ff, clip_right_ff, clip_bottom_ff;
   logic signed [PosW-1:0] csr_rd;
   csr_reg_type            csr_idx;

   logic [Stages-1:0] vld_ff;
   logic [Stages:0]   en;

   edge_type   p1_in, p1_ff;
   div_type    div_in [0:DivStages];
   div_type    div_ff [0:DivStages];
   mul_type    mul_in, mul_ff;
   result_type out_in, out_ff;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_right_ff  <= '0;
         clip_bottom_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_idx)
            REG_CLIP_LEFT:   clip_left_ff   <= csr_pwdata[PosW-1:0];
            REG_CLIP_TOP:    clip_top_ff    <= csr_pwdata[PosW-1:0];
            REG_CLIP_RIGHT:  clip_right_ff  <= csr_pwdata[PosW-1:0];
            REG_CLIP_BOTTOM: clip_bottom_ff <= csr_pwdata[PosW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_CLIP_LEFT:   csr_rd = clip_left_ff;
         REG_CLIP_TOP:    csr_rd = clip_top_ff;
         REG_CLIP_RIGHT:  csr_rd = clip_right_ff;
         REG_CLIP_BOTTOM: csr_rd = clip_bottom_ff;
         default:         csr_rd = '0;
      endcase
   end
   assign csr_prdata = {{(32-PosW){csr_rd[PosW-1]}}, csr_rd};

   // Stall chain: a stage loads when it is empty or its contents move on.
   always_comb begin
      en[Stages] = rsp_tready;
      for (int i = Stages - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end
   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < Stages; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // Stage 1: unpack and form the far edges.
   always_comb begin
      p1_in.x      = req_tdata[19:0];
      p1_in.y      = req_tdata[39:20];
      p1_in.w      = req_tdata[59:40];
      p1_in.h      = req_tdata[79:60];
      p1_in.s1     = req_tdata[97:80];
      p1_in.t1     = req_tdata[115:98];
      p1_in.s2     = req_tdata[133:116];
      p1_in.t2     = req_tdata[151:134];
      p1_in.right  = EdgeW'(p1_in.x) + EdgeW'(p1_in.w);
      p1_in.bottom = EdgeW'(p1_in.y) + EdgeW'(p1_in.h);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p1_ff <= p1_in;
      end
   end

   // Stage 2: cull and clip decisions, new position and size, divider operands.
   logic signed [EdgeW-1:0] cl, ct, cr, cb, xl, yt;
   logic                    win_on, cull, keep, clip_l, clip_r, clip_t, clip_b;
   logic signed [PosW-1:0]  xn, yn;
   logic signed [EdgeW:0]   ext_x, ext_y, rem_l, rem_r, rem_t, rem_b;

   always_comb begin
      cl = EdgeW'(clip_left_ff);
      ct = EdgeW'(clip_top_ff);
      cr = EdgeW'(clip_right_ff);
      cb = EdgeW'(clip_bottom_ff);
      xl = EdgeW'(p1_ff.x);
      yt = EdgeW'(p1_ff.y);
      win_on = (cr > cl) && (cb > ct);
      cull   = win_on && ((p1_ff.right <= cl) || (xl >= cr) ||
                          (p1_ff.bottom <= ct) || (yt >= cb));
      keep   = win_on && !cull;
      clip_l = keep && (xl < cl);
      clip_r = keep && (p1_ff.right > cr);
      clip_t = keep && (yt < ct);
      clip_b = keep && (p1_ff.bottom > cb);

      xn = clip_l ? clip_left_ff : p1_ff.x;
      yn = clip_t ? clip_top_ff  : p1_ff.y;

      ext_x = (EdgeW+1)'(p1_ff.right)  - (EdgeW+1)'(xl);
      ext_y = (EdgeW+1)'(p1_ff.bottom) - (EdgeW+1)'(yt);
      rem_l = (EdgeW+1)'(cl) - (EdgeW+1)'(xl);
      rem_r = (EdgeW+1)'(p1_ff.right) - (EdgeW+1)'(cr);
      rem_t = (EdgeW+1)'(ct) - (EdgeW+1)'(yt);
      rem_b = (EdgeW+1)'(p1_ff.bottom) - (EdgeW+1)'(cb);

      div_in[0].culled = cull;
      div_in[0].x = xn;
      div_in[0].y = yn;
      if (clip_r) begin
         div_in[0].w = sat_size((EdgeW+1)'(cr) - (EdgeW+1)'(xn));
      end else if (clip_l) begin
         div_in[0].w = sat_size((EdgeW+1)'(p1_ff.right) - (EdgeW+1)'(cl));
      end else begin
         div_in[0].w = p1_ff.w;
      end
      if (clip_b) begin
         div_in[0].h = sat_size((EdgeW+1)'(cb) - (EdgeW+1)'(yn));
      end else if (clip_t) begin
         div_in[0].h = sat_size((EdgeW+1)'(p1_ff.bottom) - (EdgeW+1)'(ct));
      end else begin
         div_in[0].h = p1_ff.h;
      end

      div_in[0].lane[LaneS1] = '{clip: clip_l, a: p1_ff.s1, b: p1_ff.s2,
                                 rem: rem_l[EdgeW-1:0], ext: ext_x[EdgeW-1:0], quo: '0};
      div_in[0].lane[LaneS2] = '{clip: clip_r, a: p1_ff.s2, b: p1_ff.s1,
                                 rem: rem_r[EdgeW-1:0], ext: ext_x[EdgeW-1:0], quo: '0};
      div_in[0].lane[LaneT1] = '{clip: clip_t, a: p1_ff.t1, b: p1_ff.t2,
                                 rem: rem_t[EdgeW-1:0], ext: ext_y[EdgeW-1:0], quo: '0};
      div_in[0].lane[LaneT2] = '{clip: clip_b, a: p1_ff.t2, b: p1_ff.t1,
                                 rem: rem_b[EdgeW-1:0], ext: ext_y[EdgeW-1:0], quo: '0};
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         div_ff[0] <= div_in[0];
      end
   end

   // Divider stages. Lanes that are not clipped divide whatever they carry; the
   // quotient is ignored for them later.
   for (genvar k = 1; k <= DivStages; k++) begin : g_div
      always_comb begin
         div_in[k] = div_ff[k-1];
         for (int l = 0; l < Lanes; l++) begin
            div_in[k].lane[l] = div_step(div_ff[k-1].lane[l]);
         end
      end

      always_ff @(posedge clock) begin
         if (en[k+1]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // Multiply stage: (b - a) * fraction.
   always_comb begin
      logic signed [TexW:0] diff;
      mul_in.culled = div_ff[DivStages].culled;
      mul_in.x      = div_ff[DivStages].x;
      mul_in.y      = div_ff[DivStages].y;
      mul_in.w      = div_ff[DivStages].w;
      mul_in.h      = div_ff[DivStages].h;
      for (int l = 0; l < Lanes; l++) begin
         diff = (TexW+1)'(div_ff[DivStages].lane[l].b) - (TexW+1)'(div_ff[DivStages].lane[l].a);
         mul_in.lane[l].clip = div_ff[DivStages].lane[l].clip;
         mul_in.lane[l].a    = div_ff[DivStages].lane[l].a;
         mul_in.lane[l].prod = ProdW'(diff) *
                               ProdW'($signed({1'b0, div_ff[DivStages].lane[l].quo}));
      end
   end

   always_ff @(posedge clock) begin
      if (en[DivStages+2]) begin
         mul_ff <= mul_in;
      end
   end

   // Output stage: finish the interpolation, zero a culled result.
   always_comb begin
      logic signed [TexW-1:0] tex [Lanes];
      for (int l = 0; l < Lanes; l++) begin
         tex[l] = mul_ff.lane[l].clip ? lerp_done(mul_ff.lane[l]) : mul_ff.lane[l].a;
      end
      if (mul_ff.culled) begin
         out_in        = '0;
         out_in.culled = 1'b1;
      end else begin
         out_in.culled = 1'b0;
         out_in.x  = mul_ff.x;
         out_in.y  = mul_ff.y;
         out_in.w  = mul_ff.w;
         out_in.h  = mul_ff.h;
         out_in.s1 = tex[LaneS1];
         out_in.t1 = tex[LaneT1];
         out_in.s2 = tex[LaneS2];
         out_in.t2 = tex[LaneT2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[DivStages+3]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = vld_ff[Stages-1];
   assign rsp_tuser  = out_ff.culled;
   assign rsp_tdata  = {out_ff.t2, out_ff.s2, out_ff.t1, out_ff.s1,
                        out_ff.h, out_ff.w, out_ff.y, out_ff.x};

endmodule

[bench/sprite_rect_clipper_checker.sv]
// Checker for the sprite rectangle clipper: predicts each result and compares it with the output.
module sprite_rect_clipper_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [151:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [151:0] rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output int           fail_count,
   output int           pending,
   output int           culled_seen,
   output int           clipped_seen
);
   import src_pkg::*;

   typedef struct packed {
      logic        culled;
      logic [151:0] data;
   } clip_result_type;

   clip_result_type expected_q[$];
   longint win_left, win_top, win_right, win_bottom;

   function automatic longint sx(input logic [31:0] v, input int bits);
      longint r;
      r = v & ((64'd1 << bits) - 1);
      if (r[bits-1]) r = r - (64'sd1 << bits);
      return r;
   endfunction

   function automatic longint frac_q16(input longint removed, input longint extent);
      return (removed <<< 16) / extent;
   endfunction

   function automatic longint tex_lerp(input longint a, input longint b, input longint f);
      return a + ((b - a) * f) / 65536;
   endfunction

   function automatic longint clamp_size(input longint v);
      return v > 524287 ? 524287 : v;
   endfunction

   function automatic clip_result_type clip_rect(input logic [151:0] d);
      longint x, y, w, h, s1, t1, s2, t2, rgt, bot, ns1, nt1, ns2, nt2;
      clip_result_type r;
      x = sx(d[19:0], 20);   y = sx(d[39:20], 20);
      w = sx(d[59:40], 20);  h = sx(d[79:60], 20);
      s1 = sx(d[97:80], 18); t1 = sx(d[115:98], 18);
      s2 = sx(d[133:116], 18); t2 = sx(d[151:134], 18);
      rgt = x + w; bot = y + h;
      ns1 = s1; nt1 = t1; ns2 = s2; nt2 = t2;
      r = '0;
      if (win_right > win_left && win_bottom > win_top) begin
         if (rgt <= win_left || x >= win_right || bot <= win_top || y >= win_bottom) begin
            r.culled = 1'b1;
            return r;
         end
         // Interpolation always uses the unclipped edges and coordinates.
         if (x < win_left) begin
            ns1 = tex_lerp(s1, s2, frac_q16(win_left - x, rgt - x));
            w = clamp_size(rgt - win_left);
         end
         if (rgt > win_right) begin
            ns2 = tex_lerp(s2, s1, frac_q16(rgt - win_right, rgt - x));
            w = clamp_size(win_right - (x < win_left ? win_left : x));
         end
         if (x < win_left) x = win_left;
         if (y < win_top) begin
            nt1 = tex_lerp(t1, t2, frac_q16(win_top - y, bot - y));
            h = clamp_size(bot - win_top);
         end
         if (bot > win_bottom) begin
            nt2 = tex_lerp(t2, t1, frac_q16(bot - win_bottom, bot - y));
            h = clamp_size(win_bottom - (y < win_top ? win_top : y));
         end
         if (y < win_top) y = win_top;
      end
      r.data = {nt2[17:0], ns2[17:0], nt1[17:0], ns1[17:0],
                h[19:0], w[19:0], y[19:0], x[19:0]};
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      clip_result_type exp_r, got_r;
      if (reset) begin
         win_left = 0; win_top = 0; win_right = 0; win_bottom = 0;
         expected_q.delete();
         fail_count = 0; culled_seen = 0; clipped_seen = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_r.culled = rsp_tuser;
            got_r.data = rsp_tdata;
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               exp_r = expected_q.pop_front();
               if (got_r.culled) culled_seen++;
               if (got_r.culled != exp_r.culled)
                  report_mismatch("culled", got_r.culled, exp_r.culled);
               for (int i = 0; i < 8; i++) begin
                  int lo, wd;
                  lo = i < 4 ? 20 * i : 80 + 18 * (i - 4);
                  wd = i < 4 ? 20 : 18;
                  if (((got_r.data >> lo) & ((152'd1 << wd) - 1)) !=
                      ((exp_r.data >> lo) & ((152'd1 << wd) - 1)))
                     report_mismatch($sformatf("field %0d", i),
                        sx(32'(got_r.data >> lo), wd), sx(32'(exp_r.data >> lo), wd));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            exp_r = clip_rect(req_tdata);
            if (!exp_r.culled && exp_r.data[79:0] != req_tdata[79:0]) clipped_seen++;
            expected_q.push_back(exp_r);
         end
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_reg_type'(csr_paddr[3:2]))
               REG_CLIP_LEFT:   win_left   = sx(csr_pwdata, 20);
               REG_CLIP_TOP:    win_top    = sx(csr_pwdata, 20);
               REG_CLIP_RIGHT:  win_right  = sx(csr_pwdata, 20);
               REG_CLIP_BOTTOM: win_bottom = sx(csr_pwdata, 20);
            endcase
         end
      end
      pending = expected_q.size();
   end

endmodule

[bench/sprite_rect_clipper_top_tb.sv]
// Top of the sprite rectangle clipper testbench: clock, reset, stimulus and verdict.
module sprite_rect_clipper_top_tb;
   import src_pkg::*;

   localparam int IdleLimit = 4000;

   logic clock = 1'b0, reset = 1'b1;
   logic req_tvalid = 1'b0, rsp_tready = 1'b0;
   logic [151:0] req_tdata = '0;
   logic req_tready, rsp_tvalid, rsp_tuser;
   logic [151:0] rsp_tdata;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   int fail_count, pending, culled_seen, clipped_seen;
   int idle_cycles = 0;
   int rect_count = 0;
   bit quiet_tail = 1'b0;
   bit long_hold = 1'b0;

   sprite_rect_clipper_top dut (.*);

   sprite_rect_clipper_checker checker_i (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: random stall bursts, a long hold-off on request, none in the tail.
   initial begin
      int n;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (1) begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 18);
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            n = $urandom_range(1, 30);
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("watchdog expired with %0d results outstanding", pending);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic csr_write(input csr_reg_type idx, input logic signed [19:0] v);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= 32'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic set_window(input logic signed [19:0] l, t, r, b);
      csr_write(REG_CLIP_LEFT, l);
      csr_write(REG_CLIP_TOP, t);
      csr_write(REG_CLIP_RIGHT, r);
      csr_write(REG_CLIP_BOTTOM, b);
   endtask

   // Wait first so that the checker has counted the last accepted beat.
   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic send_rect(input logic [19:0] x, y, w, h, input logic [17:0] s1, t1, s2, t2);
      req_tvalid <= 1'b1;
      req_tdata <= {t2, s2, t1, s1, h, w, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rect_count++;
   endtask

   // Rectangles mostly near the window so that edges overhang; some anywhere.
   task automatic send_random(input int l, t, r, b, input bit gaps);
      int x, y, w, h, n;
      if ($urandom_range(0, 4) == 0) begin
         x = $urandom; y = $urandom; w = $urandom; h = $urandom;
      end else begin
         x = l + $signed($urandom_range(0, 4000)) - 2000;
         y = t + $signed($urandom_range(0, 4000)) - 2000;
         w = (r - l) + $signed($urandom_range(0, 5000)) - 1500;
         h = (b - t) + $signed($urandom_range(0, 5000)) - 1500;
         if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 524287);
      end
      send_rect(x[19:0], y[19:0], w[19:0], h[19:0],
                18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
      if (gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         n = $urandom_range(1, 18);
         repeat (n) @(posedge clock);
      end
   endtask

   initial begin
      int wl, wt, wr, wb;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Window off after reset: every rectangle passes unchanged, extremes included.
      send_rect(20'h80000, 20'h7ffff, 20'h80000, 20'h7ffff,
                18'h20000, 18'h1ffff, 18'h1ffff, 18'h20000);
      send_rect(20'hfffff, 20'h00000, 20'hfffff, 20'h00001, 18'h3ffff, 18'h0, 18'h1, 18'h2aaaa);
      req_tvalid <= 1'b0;
      drain();
      set_window(20'sd1000, 20'sd1000, 20'sd1000, 20'sd3000);   // empty in x
      send_rect(20'd10, 20'd10, 20'd5000, 20'd5000, 18'd7, 18'd8, 18'd9, 18'd10);
      req_tvalid <= 1'b0;
      drain();
      set_window(20'sd1000, 20'sd1000, 20'sd3000, 20'sd3000);
      send_rect(20'd1200, 20'd1200, 20'd100, 20'd100, 18'd1, 18'd2, 18'd3, 18'd4);   // inside
      send_rect(20'd500, 20'd500, 20'd3000, 20'd3000, 18'h20000, 18'h1ffff, 18'h1ffff, 18'h20000);
      send_rect(20'd0, 20'd1200, 20'd1000, 20'd10, 18'd0, 18'd0, 18'd0, 18'd0);   // touches left
      send_rect(20'd3000, 20'd1200, 20'd10, 20'd10, 18'd0, 18'd0, 18'd0, 18'd0);  // at right
      send_rect(20'd1200, 20'd0, 20'd10, 20'd1000, 18'd0, 18'd0, 18'd0, 18'd0);
      send_rect(20'd1200, 20'd3000, 20'd10, 20'd10, 18'd0, 18'd0, 18'd0, 18'd0);
      send_rect(20'd2000, 20'd2000, 20'hfff00, 20'hfff00, 18'd5, 18'd5, 18'd5, 18'd5); // negative
      send_rect(20'd999, 20'd999, 20'd2002, 20'd2002, 18'h1ffff, 18'h20000, 18'h20000, 18'h1ffff);
      req_tvalid <= 1'b0;
      drain();
      // Widest window: rectangles at the ends of the position range.
      set_window(20'sh80000, 20'sh80000, 20'sh7ffff, 20'sh7ffff);
      send_rect(20'h80000, 20'h80000, 20'h7ffff, 20'h7ffff, 18'd100, 18'd100, 18'h3ff00, 18'd9);
      send_rect(20'h7ffff, 20'h7ffff, 20'h7ffff, 20'h7ffff, 18'd100, 18'd100, 18'h3ff00, 18'd9);
      send_rect(20'h90000, 20'h90000, 20'h7ffff, 20'h7ffff,
                18'h20000, 18'h1ffff, 18'h1ffff, 18'h20000);
      req_tvalid <= 1'b0;
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         wl = $signed($urandom_range(0, 40000)) - 20000;
         wt = $signed($urandom_range(0, 40000)) - 20000;
         wr = wl + (phase == 7 ? -5 : $urandom_range(1, 8000));
         wb = wt + $urandom_range(1, 8000);
         set_window(wl[19:0], wt[19:0], wr[19:0], wb[19:0]);
         if (phase == 2) long_hold = 1'b1;   // sender keeps offering while the output stalls
         if (phase == 6) quiet_tail = 1'b1;
         for (int i = 0; i < 200; i++) begin
            send_random(wl, wt, wr, wb, !quiet_tail);
            if (phase == 4 && i == 100) begin
               req_tvalid <= 1'b0;
               drain();
            end
         end
         req_tvalid <= 1'b0;
         drain();
      end

      $display("covered %0d rectangles over several clip windows: %0d culled, %0d clipped",
               rect_count, culled_seen, clipped_seen);
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
